[src/pfq_pkg.sv]
// ----------------------------------------------------------------------------
// pfq_pkg: shared types and constants of the priority packet queue
// Entry, request and response layouts, operation and status codes, the
// controller state type and the controller/datapath command and status.
// ----------------------------------------------------------------------------
package pfq_pkg;

  localparam int QUEUE_DEPTH = 16;
  localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
  localparam int RC_W        = 5;
  localparam int COUNT_MAX   = 31;

  // operation codes
  localparam logic [1:0] KIND_ENQ = 2'd0;
  localparam logic [1:0] KIND_DEQ = 2'd1;
  localparam logic [1:0] KIND_CLR = 2'd2;

  // status codes
  localparam logic [1:0] STAT_DONE  = 2'd0;
  localparam logic [1:0] STAT_FULL  = 2'd1;
  localparam logic [1:0] STAT_EMPTY = 2'd2;

  typedef struct packed {
    logic [1:0]        kind;
    logic signed [7:0] priority_req;
    logic [15:0]       channel;
    logic [7:0]        command;
    logic [15:0]       payload_handle;
    logic [15:0]       payload_length;
    logic              clear_all;
  } pfq_req_t;

  typedef struct packed {
    logic [1:0]        status;
    logic signed [7:0] out_priority;
    logic [15:0]       out_channel;
    logic [7:0]        out_command;
    logic [15:0]       out_handle;
    logic [15:0]       out_length;
    logic [RC_W-1:0]   removed_count;
  } pfq_rsp_t;

  typedef struct packed {
    logic signed [7:0] pri;
    logic [15:0]       channel;
    logic [7:0]        command;
    logic [15:0]       handle;
    logic [15:0]       length;
  } pfq_entry_t;

  typedef enum logic [0:0] {
    ST_IDLE,
    ST_EXEC
  } pfq_state_t;

  typedef struct packed {
    logic capture;   // latch the accepted request
    logic clr_step;  // remove the first matching entry
    logic finish;    // complete the operation and load the response
  } pfq_cmd_t;

  typedef struct packed {
    logic is_clear;
    logic any_match;
  } pfq_stat_t;

endpackage

[src/pfq_if.sv]
// ----------------------------------------------------------------------------
// pfq_if: handshake channels of the priority packet queue
// Request, response and configuration channels, each valid/ready.
// ----------------------------------------------------------------------------
interface pfq_req_if;
  logic              valid;
  logic              ready;
  pfq_pkg::pfq_req_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface pfq_rsp_if;
  logic              valid;
  logic              ready;
  pfq_pkg::pfq_rsp_t data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

interface pfq_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] data;
  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

[src/pfq_datapath.sv]
// ----------------------------------------------------------------------------
// pfq_datapath: shift-register cell array and response register
// Sorted insert, head removal and one-at-a-time purge of matching entries.
// ----------------------------------------------------------------------------
module pfq_datapath (
  input  logic                clk,
  input  logic                rst,
  input  pfq_pkg::pfq_cmd_t   cmd,
  output pfq_pkg::pfq_stat_t  stat,
  input  logic                cfg_we,
  input  logic [7:0]          cfg_data,
  input  pfq_pkg::pfq_req_t   req_data,
  output pfq_pkg::pfq_rsp_t   rsp_data
);

  pfq_pkg::pfq_entry_t cells    [pfq_pkg::QUEUE_DEPTH];
  pfq_pkg::pfq_entry_t shift_up [pfq_pkg::QUEUE_DEPTH];
  pfq_pkg::pfq_entry_t shift_dn [pfq_pkg::QUEUE_DEPTH];
  pfq_pkg::pfq_entry_t new_entry;
  pfq_pkg::pfq_req_t   op;
  pfq_pkg::pfq_rsp_t   rsp_next;

  logic [pfq_pkg::CNT_W-1:0]       count;
  logic [pfq_pkg::CNT_W-1:0]       removed;
  logic [7:0]                      dcc;
  logic [pfq_pkg::QUEUE_DEPTH-1:0] valid, gt, match, take, ins, rm;
  logic                            full, empty;
  logic                            do_enq, do_deq;

  assign new_entry = '{pri:     op.priority_req,
                       channel: op.channel,
                       command: op.command,
                       handle:  op.payload_handle,
                       length:  op.payload_length};

  assign full   = count == pfq_pkg::CNT_W'(pfq_pkg::QUEUE_DEPTH);
  assign empty  = count == '0;
  assign do_enq = cmd.finish && op.kind == pfq_pkg::KIND_ENQ && !full;
  assign do_deq = cmd.finish && op.kind == pfq_pkg::KIND_DEQ && !empty;

  genvar g;
  generate
    for (g = 0; g < pfq_pkg::QUEUE_DEPTH; g++) begin : g_cell
      localparam logic [pfq_pkg::QUEUE_DEPTH-1:0] LowMask =
        {pfq_pkg::QUEUE_DEPTH{1'b1}} >> (pfq_pkg::QUEUE_DEPTH - 1 - g);

      assign valid[g] = pfq_pkg::CNT_W'(g) < count;
      assign gt[g]    = valid[g] && ($signed(op.priority_req) > $signed(cells[g].pri));
      assign match[g] = valid[g] && cells[g].channel == op.channel &&
                        (op.clear_all || cells[g].command == dcc);
      // new entry goes at the first cell it outranks, or at the tail
      assign take[g]  = valid[g] ? gt[g] : (pfq_pkg::CNT_W'(g) == count);
      // cell lies at or beyond the first match
      assign rm[g]    = |(match & LowMask);

      if (g == 0) begin : g_first
        assign ins[g]      = take[g];
        assign shift_dn[g] = new_entry;
      end else begin : g_rest
        assign ins[g]      = take[g] && !take[g-1];
        assign shift_dn[g] = cells[g-1];
      end

      if (g == pfq_pkg::QUEUE_DEPTH - 1) begin : g_last
        assign shift_up[g] = cells[g];
      end else begin : g_inner
        assign shift_up[g] = cells[g+1];
      end

      always_ff @(posedge clk) begin
        if (do_enq) begin
          if (ins[g]) begin
            cells[g] <= new_entry;
          end else if (take[g]) begin
            cells[g] <= shift_dn[g];
          end
        end else if (do_deq) begin
          cells[g] <= shift_up[g];
        end else if (cmd.clr_step && rm[g]) begin
          cells[g] <= shift_up[g];
        end
      end
    end
  endgenerate

  assign stat.is_clear  = op.kind == pfq_pkg::KIND_CLR;
  assign stat.any_match = |match;

  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      removed <= '0;
      dcc     <= 8'd0;
    end else begin
      if (cfg_we) begin
        dcc <= cfg_data;
      end
      if (cmd.capture) begin
        removed <= '0;
      end else if (cmd.clr_step) begin
        removed <= removed + 1'b1;
        count   <= count - 1'b1;
      end else if (do_enq) begin
        count <= count + 1'b1;
      end else if (do_deq) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      op <= req_data;
    end
  end

  always_comb begin
    rsp_next = '0;
    case (op.kind)
      pfq_pkg::KIND_ENQ: begin
        rsp_next.status = full ? pfq_pkg::STAT_FULL : pfq_pkg::STAT_DONE;
      end
      pfq_pkg::KIND_DEQ: begin
        if (empty) begin
          rsp_next.status = pfq_pkg::STAT_EMPTY;
        end else begin
          rsp_next.status       = pfq_pkg::STAT_DONE;
          rsp_next.out_priority = cells[0].pri;
          rsp_next.out_channel  = cells[0].channel;
          rsp_next.out_command  = cells[0].command;
          rsp_next.out_handle   = cells[0].handle;
          rsp_next.out_length   = cells[0].length;
        end
      end
      pfq_pkg::KIND_CLR: begin
        rsp_next.status        = pfq_pkg::STAT_DONE;
        rsp_next.removed_count = (32'(removed) > 32'(pfq_pkg::COUNT_MAX)) ?
                                 pfq_pkg::RC_W'(pfq_pkg::COUNT_MAX) :
                                 pfq_pkg::RC_W'(removed);
      end
      default: begin
        rsp_next.status = pfq_pkg::STAT_DONE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) begin
      rsp_data <= rsp_next;
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= pfq_pkg::CNT_W'(pfq_pkg::QUEUE_DEPTH))
    else $error("entry count beyond queue depth");

  a_step_has_match: assert property (@(posedge clk) disable iff (rst)
    cmd.clr_step |-> stat.any_match && stat.is_clear)
    else $error("purge step with no matching entry");

endmodule

[src/pfq_ctrl.sv]
// ----------------------------------------------------------------------------
// pfq_ctrl: operation sequencer of the priority packet queue
// Accepts a request, steps the purge loop, and owns the response valid.
// ----------------------------------------------------------------------------
module pfq_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_ready,
  output logic               rsp_valid,
  input  logic               rsp_ready,
  input  pfq_pkg::pfq_stat_t stat,
  output pfq_pkg::pfq_cmd_t  cmd
);

  pfq_pkg::pfq_state_t state, state_next;
  logic                out_free;

  assign out_free = !rsp_valid || rsp_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= pfq_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    req_ready  = 1'b0;
    case (state)
      pfq_pkg::ST_IDLE: begin
        req_ready = 1'b1;
        if (req_valid) begin
          cmd.capture = 1'b1;
          state_next  = pfq_pkg::ST_EXEC;
        end
      end
      pfq_pkg::ST_EXEC: begin
        if (stat.is_clear && stat.any_match) begin
          cmd.clr_step = 1'b1;
        end else if (out_free) begin
          cmd.finish = 1'b1;
          state_next = pfq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_next = pfq_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (cmd.finish) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  a_accept_to_exec: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> state == pfq_pkg::ST_EXEC)
    else $error("accepted beat did not start execution");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    cmd.finish |-> !rsp_valid || rsp_ready)
    else $error("response overwritten before it was taken");

endmodule

[src/priority_fifo_packet_queue_top.sv]
// ----------------------------------------------------------------------------
// priority_fifo_packet_queue_top: priority-ordered descriptor queue
// Sixteen-entry transmit queue with sorted insert, head dequeue and purge.
// ----------------------------------------------------------------------------
// Holds up to 16 command descriptors (priority, channel, command, handle,
// length) in a shift-register cell array kept in descending priority order;
// equal priorities leave oldest first. Every request beat gives exactly one
// response beat. Each request is accepted, then executed into the response
// register; kind 3 does nothing. A channel clear first removes its N
// matching entries, one purge step per entry, and then executes: the cell
// array drops one matching entry per cycle, the first one, shifting the rest
// down, which keeps the survivors in order. A new request is taken once the
// previous one has been executed, even while its response beat still waits
// in the output register; execution stalls only if that register is still
// occupied. The data command code register may be written at any time the
// queue is idle; its port is always ready. No clearing pass after reset:
// the fill count alone marks which cells hold entries.
// ----------------------------------------------------------------------------
module priority_fifo_packet_queue_top (
  input logic      clk,
  input logic      rst,
  pfq_req_if.sink  req,
  pfq_rsp_if.source rsp,
  pfq_cfg_if.sink  cfg
);

  pfq_pkg::pfq_cmd_t  cmd;
  pfq_pkg::pfq_stat_t stat;

  // config writes land straight in the datapath register
  assign cfg.ready = 1'b1;

  pfq_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req.valid),
    .req_ready (req.ready),
    .rsp_valid (rsp.valid),
    .rsp_ready (rsp.ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  pfq_datapath u_datapath (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .stat     (stat),
    .cfg_we   (cfg.valid),
    .cfg_data (cfg.data),
    .req_data (req.data),
    .rsp_data (rsp.data)
  );

endmodule

[sim/priority_fifo_packet_queue_top_tb.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// priority_fifo_packet_queue_top_tb: self-checking bench for the priority queue
// Drives enqueue, dequeue, channel clear and unused request beats with random
// gaps and response stalls. A behavioural copy of the queue predicts every
// response beat, which is compared field by field as it is accepted.
// ----------------------------------------------------------------------------
module priority_fifo_packet_queue_top_tb;

  // Request kind with no operation behind it; the block must ignore it.
  localparam logic [1:0] KIND_UNUSED = 2'd3;
  // Data command code used by the directed clear checks.
  localparam logic [7:0] DIR_DATA_CODE = 8'h5A;

  logic clk = 1'b0;
  logic rst;

  pfq_req_if req_ch ();
  pfq_rsp_if rsp_ch ();
  pfq_cfg_if cfg_ch ();

  priority_fifo_packet_queue_top dut (
    .clk (clk),
    .rst (rst),
    .req (req_ch),
    .rsp (rsp_ch),
    .cfg (cfg_ch)
  );

  always #2 clk = ~clk;

  // Behavioural image of the queue: index 0 is the head.
  pfq_pkg::pfq_entry_t model_entries[$];
  logic [7:0]          data_code_q;
  pfq_pkg::pfq_rsp_t   pending_rsp[$];

  bit gaps_on = 1'b1;
  int n_errors;
  int n_sent, n_deq_ok, n_full, n_empty, n_purged, peak_fill;

  // Sorted insert, head removal and purge, applied to the image; returns the
  // response beat the block owes for this request.
  function automatic pfq_pkg::pfq_rsp_t predict_queue_op(input pfq_pkg::pfq_req_t op);
    pfq_pkg::pfq_rsp_t   r;
    pfq_pkg::pfq_entry_t e;
    pfq_pkg::pfq_entry_t kept[$];
    int                  pos;
    int                  removed;
    r = '0;
    case (op.kind)
      pfq_pkg::KIND_ENQ: begin
        if (model_entries.size() >= pfq_pkg::QUEUE_DEPTH) begin
          r.status = pfq_pkg::STAT_FULL;
        end else begin
          // new entry goes behind everything of equal or higher priority
          pos = 0;
          while (pos < model_entries.size() && op.priority_req <= model_entries[pos].pri)
            pos++;
          e.pri     = op.priority_req;
          e.channel = op.channel;
          e.command = op.command;
          e.handle  = op.payload_handle;
          e.length  = op.payload_length;
          model_entries.insert(pos, e);
          if (model_entries.size() > peak_fill) peak_fill = model_entries.size();
        end
      end
      pfq_pkg::KIND_DEQ: begin
        if (model_entries.size() == 0) begin
          r.status = pfq_pkg::STAT_EMPTY;
        end else begin
          e = model_entries.pop_front();
          r.out_priority = e.pri;
          r.out_channel  = e.channel;
          r.out_command  = e.command;
          r.out_handle   = e.handle;
          r.out_length   = e.length;
          n_deq_ok++;
        end
      end
      pfq_pkg::KIND_CLR: begin
        removed = 0;
        foreach (model_entries[i]) begin
          if (model_entries[i].channel == op.channel &&
              (op.clear_all || model_entries[i].command == data_code_q))
            removed++;
          else
            kept.push_back(model_entries[i]);
        end
        model_entries = kept;
        r.removed_count = pfq_pkg::RC_W'(removed > pfq_pkg::COUNT_MAX ?
                                         pfq_pkg::COUNT_MAX : removed);
      end
      default: ;  // unused kind: queue untouched, all-zero response
    endcase
    return r;
  endfunction

  function automatic pfq_pkg::pfq_req_t make_op(input logic [1:0] kind,
                                                input logic [7:0] pri,
                                                input logic [15:0] ch,
                                                input logic [7:0] cmd,
                                                input logic [15:0] hnd,
                                                input logic [15:0] len,
                                                input logic all);
    pfq_pkg::pfq_req_t op;
    op.kind           = kind;
    op.priority_req   = pri;
    op.channel        = ch;
    op.command        = cmd;
    op.payload_handle = hnd;
    op.payload_length = len;
    op.clear_all      = all;
    return op;
  endfunction

  // Random request. Channels mostly, and priorities half the time, come from a narrow set so
  // that clears find matches and equal priorities pile up; the rest span the
  // full field.
  function automatic pfq_pkg::pfq_req_t random_op(input int enq_pct, input int deq_pct,
                                                  input int clr_pct);
    pfq_pkg::pfq_req_t op;
    int                pick;
    pick = $urandom_range(99);
    if (pick < enq_pct)                          op.kind = pfq_pkg::KIND_ENQ;
    else if (pick < enq_pct + deq_pct)           op.kind = pfq_pkg::KIND_DEQ;
    else if (pick < enq_pct + deq_pct + clr_pct) op.kind = pfq_pkg::KIND_CLR;
    else                                         op.kind = KIND_UNUSED;
    op.priority_req   = $urandom_range(1) ? 8'($urandom_range(2)) : 8'($urandom);
    op.channel        = ($urandom_range(3) != 0) ? 16'($urandom_range(3)) : 16'($urandom);
    op.command        = $urandom_range(1) ? data_code_q : 8'($urandom);
    op.payload_handle = 16'($urandom);
    op.payload_length = 16'($urandom);
    op.clear_all      = 1'($urandom_range(1));
    return op;
  endfunction

  // One request beat. Valid is left high on return so back-to-back beats
  // never see a low/high pair of assignments in the same step.
  task automatic send_op(input pfq_pkg::pfq_req_t op);
    if (gaps_on) begin
      while ($urandom_range(99) < 16) begin
        req_ch.valid <= 1'b0;
        @(posedge clk);
      end
    end
    req_ch.valid <= 1'b1;
    req_ch.data  <= op;
    do @(posedge clk); while (!req_ch.ready);
    // beat taken at this edge: predict in acceptance order
    pending_rsp.push_back(predict_queue_op(op));
    n_sent++;
  endtask

  // Stop sending and wait for every owed response beat.
  task automatic drain_queue();
    req_ch.valid <= 1'b0;
    while (pending_rsp.size() != 0) @(posedge clk);
  endtask

  // Only called with the block idle (after drain_queue).
  task automatic write_data_code(input logic [7:0] code);
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= code;
    do @(posedge clk); while (!cfg_ch.ready);
    cfg_ch.valid <= 1'b0;
    data_code_q = code;
  endtask

  task automatic check_field(input string what, input logic [15:0] want,
                             input logic [15:0] got);
    if (want !== got) begin
      n_errors++;
      $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, what, want, got);
    end
  endtask

  // Response side: random stalls on ready, every accepted beat checked
  // against the oldest prediction. Values seen here are pre-edge.
  always @(posedge clk) begin : rsp_check
    pfq_pkg::pfq_rsp_t want;
    pfq_pkg::pfq_rsp_t got;
    if (!rst && rsp_ch.valid && rsp_ch.ready) begin
      got = rsp_ch.data;
      if (pending_rsp.size() == 0) begin
        n_errors++;
        $display("%0t ns: response beat with nothing expected, expected none, got %0h",
                 $time, got);
      end else begin
        want = pending_rsp.pop_front();
        check_field("status",        16'(want.status),        16'(got.status));
        check_field("out_priority",  16'(want.out_priority),  16'(got.out_priority));
        check_field("out_channel",   want.out_channel,        got.out_channel);
        check_field("out_command",   16'(want.out_command),   16'(got.out_command));
        check_field("out_handle",    want.out_handle,         got.out_handle);
        check_field("out_length",    want.out_length,         got.out_length);
        check_field("removed_count", 16'(want.removed_count), 16'(got.removed_count));
        if (want.status == pfq_pkg::STAT_FULL)  n_full++;
        if (want.status == pfq_pkg::STAT_EMPTY) n_empty++;
        n_purged += want.removed_count;
      end
    end
    rsp_ch.ready <= !gaps_on || ($urandom_range(99) >= 16);
  end

  // Dequeue on an empty queue, and a beat of the unused kind
  // with every field set: none may change anything.
  task automatic test_empty_and_unused();
    send_op(make_op(pfq_pkg::KIND_DEQ, 8'h00, 16'h0000, 8'h00, 16'h0000, 16'h0000, 1'b0));
    send_op(make_op(KIND_UNUSED, 8'hFF, 16'hFFFF, 8'hFF, 16'hFFFF, 16'hFFFF, 1'b1));
  endtask

  // Sixteen entries over three channels, extremes of every field, ties of
  // priority; then one more beat that must be refused as full.
  task automatic test_fill_to_full();
    drain_queue();
    write_data_code(DIR_DATA_CODE);
    send_op(make_op(pfq_pkg::KIND_ENQ, 8'sd10, 16'd5, DIR_DATA_CODE, 16'h0101, 16'd1, 1'b0));
    send_op(make_op(pfq_pkg::KIND_ENQ, -8'sd128, 16'h0000, 8'hFF, 16'hFFFF, 16'h0000,
                    1'b0));
    send_op(make_op(pfq_pkg::KIND_ENQ, 8'sd127, 16'hFFFF, 8'hFF, 16'hFFFF, 16'hFFFF, 1'b1));
    send_op(make_op(pfq_pkg::KIND_ENQ, 8'sd10, 16'd5, 8'h01, 16'h0102, 16'd2, 1'b0));
    send_op(make_op(pfq_pkg::KIND_ENQ, 8'sd0, 16'h0000, DIR_DATA_CODE, 16'h1234, 16'h8000,
                    1'b0));
    send_op(make_op(pfq_pkg::KIND_ENQ, -8'sd3, 16'd5, DIR_DATA_CODE, 16'h0103, 16'd3, 1'b0));
    send_op(make_op(pfq_pkg::KIND_ENQ, -8'sd128, 16'hFFFF, DIR_DATA_CODE, 16'h0000,
                    16'h0000, 1'b0));
    send_op(make_op(pfq_pkg::KIND_ENQ, 8'sd99, 16'd5, DIR_DATA_CODE, 16'h0104, 16'd4, 1'b0));
    send_op(make_op(pfq_pkg::KIND_ENQ, 8'sd127, 16'h0000, 8'h00, 16'h0000, 16'hFFFF, 1'b0));
    send_op(make_op(pfq_pkg::KIND_ENQ, 8'sd10, 16'd5, DIR_DATA_CODE, 16'h0105, 16'd5, 1'b0));
    send_op(make_op(pfq_pkg::KIND_ENQ, 8'sd1, 16'hFFFF, 8'h00, 16'h5555, 16'hAAAA, 1'b0));
    send_op(make_op(pfq_pkg::KIND_ENQ, -8'sd3, 16'd5, 8'hFF, 16'h0106, 16'd6, 1'b0));
    send_op(make_op(pfq_pkg::KIND_ENQ, 8'sd0, 16'h0000, 8'h5B, 16'hABCD, 16'h0001, 1'b0));
    send_op(make_op(pfq_pkg::KIND_ENQ, 8'sd0, 16'd5, DIR_DATA_CODE, 16'h0107, 16'd7, 1'b0));
    send_op(make_op(pfq_pkg::KIND_ENQ, 8'sd1, 16'hFFFF, 8'h80, 16'hAAAA, 16'h5555, 1'b0));
    send_op(make_op(pfq_pkg::KIND_ENQ, 8'sd50, 16'd5, 8'h00, 16'h0108, 16'd8, 1'b0));
    // queue now full
    send_op(make_op(pfq_pkg::KIND_ENQ, 8'sd127, 16'h0042, 8'h42, 16'h4242, 16'h4242, 1'b0));
  endtask

  // Selective purge of data entries, full purge, purge of a channel that
  // holds nothing, then a full purge of what the selective one left.
  task automatic test_channel_clear();
    send_op(make_op(pfq_pkg::KIND_CLR, 8'h00, 16'd5, 8'h00, 16'h0000, 16'h0000, 1'b0));
    send_op(make_op(pfq_pkg::KIND_CLR, 8'h00, 16'hFFFF, 8'h00, 16'h0000, 16'h0000, 1'b1));
    send_op(make_op(pfq_pkg::KIND_CLR, 8'h00, 16'h0077, 8'h00, 16'h0000, 16'h0000, 1'b0));
    send_op(make_op(pfq_pkg::KIND_CLR, 8'h00, 16'd5, 8'h00, 16'h0000, 16'h0000, 1'b1));
  endtask

  // Four survivors must leave highest first, ties oldest first.
  task automatic test_priority_order();
    repeat (4)
      send_op(make_op(pfq_pkg::KIND_DEQ, 8'h00, 16'h0000, 8'h00, 16'h0000, 16'h0000, 1'b0));
  endtask

  // One traffic phase: drain, set the data code, then random beats until
  // n_ops real operations have gone in (unused beats do not count).
  task automatic run_traffic(input int n_ops, input logic [7:0] code, input int enq_pct,
                             input int deq_pct, input int clr_pct);
    pfq_pkg::pfq_req_t op;
    int                done_ops;
    done_ops = 0;
    drain_queue();
    write_data_code(code);
    while (done_ops < n_ops) begin
      op = random_op(enq_pct, deq_pct, clr_pct);
      send_op(op);
      if (op.kind != KIND_UNUSED) done_ops++;
    end
  endtask

  // Fill-heavy, balanced, unstalled and drain-heavy phases; the data code
  // goes through both extremes and two random values.
  task automatic test_random_traffic();
    run_traffic(100, 8'h00, 60, 25, 12);
    run_traffic(100, 8'hFF, 45, 45, 7);
    gaps_on = 1'b0;  // long stretch with neither side idling
    run_traffic(100, 8'($urandom), 55, 30, 12);
    gaps_on = 1'b1;
    run_traffic(100, 8'($urandom), 35, 55, 7);
  endtask

  initial begin
    rst          <= 1'b1;
    req_ch.valid <= 1'b0;
    req_ch.data  <= '0;
    cfg_ch.valid <= 1'b0;
    cfg_ch.data  <= '0;
    data_code_q  = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    test_empty_and_unused();
    test_fill_to_full();
    test_channel_clear();
    test_priority_order();
    test_random_traffic();

    drain_queue();
    // idle time before the summary, with room for the longest clear
    repeat (pfq_pkg::QUEUE_DEPTH + 8) @(posedge clk);

    $display("Ran %0d request beats: %0d dequeued entries, %0d empty dequeues,",
             n_sent, n_deq_ok, n_empty);
    $display("%0d full refusals, %0d purged entries; peak fill %0d of %0d",
             n_full, n_purged, peak_fill, pfq_pkg::QUEUE_DEPTH);
    if (n_errors == 0)
      $display("Test completed successfully");
    else
      $display("Test completed with failures");
    $finish;
  end

  // Watchdog: far beyond the slowest correct run of some 430 beats.
  initial begin
    #2000000;
    $display("Timeout waiting for the queue to respond");
    $display("Test completed with failures");
    $finish;
  end

endmodule
